FILE: hw/rtl/cils_pkg.sv
// Shared types and constants of the C integer literal scanner.
package cils_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned KIND_W  = 3;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT    = 3'd0,
        KIND_UINT   = 3'd1,
        KIND_LONG   = 3'd2,
        KIND_ULONG  = 3'd3,
        KIND_LLONG  = 3'd4,
        KIND_ULLONG = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_HEXPFX = 3'd2,
        PH_DIGITS = 3'd3,
        PH_AFTU   = 3'd4,
        PH_AFTL   = 3'd5,
        PH_SUFEND = 3'd6
    } phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               exceeds_32;
        logic               exceeds_64;
        kind_t              kind;
        logic               hex_missing;
        logic               float_follows;
    } result_t;

endpackage

FILE: hw/rtl/c_integer_literal_scanner.sv
// Top level of the C integer literal scanner: input register, scan core, result register.
//
// The scanner takes one source byte per clock unless stalled. An accepted byte is held in the
// input register, then drives one step of the state machine and its radix multiply-add; any
// result it causes is loaded into the result register at the edge of that step, so m_tvalid
// rises as the byte that ends a literal leaves the input register. Bytes may follow each other
// in every cycle; any byte, whether it ends a literal or not, waits in the input register while a
// previous result sits in the result register and m_tready is low. A result is produced for the
// first byte that does not belong to a literal, including a start byte that opens the next one.
module c_integer_literal_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [6:0]  m_tuser    // [0] exceeds_32, [1] exceeds_64, [4:2] kind,
                                   // [5] hex_missing, [6] float_follows
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_ch_reg;
    logic              in_start_reg;
    logic              out_valid_reg, out_valid_next;
    cils_pkg::result_t out_res_reg;
    logic              out_free;
    logic              fire;
    logic              res_valid;
    cils_pkg::result_t res;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    cils_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (fire),
        .ch        (in_ch_reg),
        .start     (in_start_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg    <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.value;
    assign m_tuser  = {out_res_reg.float_follows, out_res_reg.hex_missing, out_res_reg.kind,
                       out_res_reg.exceeds_64, out_res_reg.exceeds_32};

    // The input side may only stall while a finished result is still waiting.
    a_stall_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A missing hex digit result carries a zero value, int kind and no range flags.
    a_hexmiss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.hex_missing) |->
            (out_res_reg.value == '0 && out_res_reg.kind == cils_pkg::KIND_INT &&
             !out_res_reg.exceeds_32 && !out_res_reg.exceeds_64 &&
             !out_res_reg.float_follows))
        else $error("hex_missing result has stray fields");

    // Leaving 64 bits always implies leaving 32 bits.
    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.exceeds_64) |-> out_res_reg.exceeds_32)
        else $error("exceeds_64 without exceeds_32");

    // A float terminator only follows bare digits, so no suffix kind can come with it.
    a_float_no_suffix: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.float_follows) |-> out_res_reg.kind == cils_pkg::KIND_INT)
        else $error("float_follows with a suffix kind");

    // A result is only loaded when the result register is free to take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("pending result overwritten");

endmodule

FILE: hw/rtl/cils_fold.sv
// Folds one digit into the 64-bit accumulator and updates the sticky range flags.
module cils_fold (
    input  logic [cils_pkg::VALUE_W-1:0] accum,
    input  logic                         over32,
    input  logic                         over64,
    input  cils_pkg::radix_t             radix,
    input  logic [3:0]                   digit,
    output logic [cils_pkg::VALUE_W-1:0] accum_next,
    output logic                         over32_next,
    output logic                         over64_next
);

    localparam int unsigned WIDE_W = cils_pkg::VALUE_W + 4;

    logic [WIDE_W-1:0] a_ext;
    logic [WIDE_W-1:0] prod;
    logic [WIDE_W-1:0] sum;
    logic              carry_out;

    assign a_ext = {4'b0000, accum};

    // Radix 10 is built as 8a + 2a, the others are plain shifts.
    always_comb begin
        case (radix)
            cils_pkg::RX_HEX: prod = a_ext << 4;
            cils_pkg::RX_OCT: prod = a_ext << 3;
            default:          prod = (a_ext << 3) + (a_ext << 1);
        endcase
    end

    assign sum         = prod + {{(WIDE_W-4){1'b0}}, digit};
    assign carry_out   = |sum[WIDE_W-1:cils_pkg::VALUE_W];
    assign accum_next  = sum[cils_pkg::VALUE_W-1:0];
    assign over64_next = over64 | carry_out;
    assign over32_next = over32 | over64_next | (|sum[cils_pkg::VALUE_W-1:32]);

endmodule

FILE: hw/rtl/cils_core.sv
// Literal state machine: base selection, digit folding, suffixes and result forming.
module cils_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        ch,
    input  logic              start,
    output logic              res_valid,
    output cils_pkg::result_t res
);

    localparam logic [4:0] NO_DIGIT = 5'd16;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_UL    = 8'h4C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;

    function automatic logic [4:0] digit_val(input logic [7:0] c, input cils_pkg::radix_t rx);
        logic [4:0] d;
        logic [4:0] r;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            d = {1'b0, c[3:0]} + 5'd9;
        end
        case (rx)
            cils_pkg::RX_HEX: r = d;
            cils_pkg::RX_OCT: r = (d < 5'd8) ? d : NO_DIGIT;
            default:          r = (d < 5'd10) ? d : NO_DIGIT;
        endcase
        return r;
    endfunction

    cils_pkg::phase_t                 phase_reg, phase_next;
    cils_pkg::radix_t                 radix_reg, radix_next;
    logic [cils_pkg::VALUE_W-1:0]     accum_reg, accum_next;
    logic                             over32_reg, over32_next;
    logic                             over64_reg, over64_next;
    cils_pkg::kind_t                  kind_reg, kind_next;

    logic [4:0]                       dig;
    logic                             dig_ok;
    logic                             is_x, is_u, is_l, is_float_ch;
    logic                             is_nz_digit;
    cils_pkg::phase_t                 begin_phase, close_phase;
    logic [cils_pkg::VALUE_W-1:0]     fold_accum;
    logic                             fold_over32, fold_over64;

    assign dig         = digit_val(ch, radix_reg);
    assign dig_ok      = !start && (dig != NO_DIGIT);
    assign is_x        = !start && (ch == CH_LX || ch == CH_UX);
    assign is_u        = !start && (ch == CH_LU || ch == CH_UU);
    assign is_l        = !start && (ch == CH_LL || ch == CH_UL);
    assign is_float_ch = (ch == CH_DOT || ch == CH_LE || ch == CH_UE);
    assign is_nz_digit = (ch >= CH_ONE && ch <= CH_NINE);

    assign begin_phase = (ch == CH_ZERO) ? cils_pkg::PH_ZERO :
                         (is_nz_digit ? cils_pkg::PH_DIGITS : cils_pkg::PH_IDLE);
    assign close_phase = start ? begin_phase : cils_pkg::PH_IDLE;

    cils_fold u_fold (
        .accum       (accum_reg),
        .over32      (over32_reg),
        .over64      (over64_reg),
        .radix       (radix_reg),
        .digit       (dig[3:0]),
        .accum_next  (fold_accum),
        .over32_next (fold_over32),
        .over64_next (fold_over64)
    );

    always_comb begin
        case (phase_reg)
            cils_pkg::PH_IDLE:   phase_next = start ? begin_phase : cils_pkg::PH_IDLE;
            cils_pkg::PH_HEXPFX: phase_next = dig_ok ? cils_pkg::PH_DIGITS : close_phase;
            cils_pkg::PH_ZERO, cils_pkg::PH_DIGITS: begin
                if (phase_reg == cils_pkg::PH_ZERO && is_x) begin
                    phase_next = cils_pkg::PH_HEXPFX;
                end else if (dig_ok) begin
                    phase_next = cils_pkg::PH_DIGITS;
                end else if (is_u) begin
                    phase_next = cils_pkg::PH_AFTU;
                end else if (is_l) begin
                    phase_next = cils_pkg::PH_AFTL;
                end else begin
                    phase_next = close_phase;
                end
            end
            cils_pkg::PH_AFTU:   phase_next = is_l ? cils_pkg::PH_AFTL : close_phase;
            cils_pkg::PH_AFTL:   phase_next = is_l ? cils_pkg::PH_SUFEND : close_phase;
            default:             phase_next = close_phase;
        endcase
    end

    always_comb begin
        logic close;
        logic hexmiss;
        logic fl;
        close       = 1'b0;
        hexmiss     = 1'b0;
        fl          = 1'b0;
        res_valid   = 1'b0;
        radix_next  = radix_reg;
        accum_next  = accum_reg;
        over32_next = over32_reg;
        over64_next = over64_reg;
        kind_next   = kind_reg;
        case (phase_reg)
            cils_pkg::PH_IDLE: begin
                close = 1'b0;
            end
            cils_pkg::PH_HEXPFX: begin
                if (dig_ok) begin
                    accum_next  = fold_accum;
                    over32_next = fold_over32;
                    over64_next = fold_over64;
                end else begin
                    close   = 1'b1;
                    hexmiss = 1'b1;
                end
            end
            cils_pkg::PH_ZERO, cils_pkg::PH_DIGITS: begin
                if (phase_reg == cils_pkg::PH_ZERO && is_x) begin
                    radix_next = cils_pkg::RX_HEX;
                end else if (dig_ok) begin
                    accum_next  = fold_accum;
                    over32_next = fold_over32;
                    over64_next = fold_over64;
                end else if (is_u) begin
                    kind_next = cils_pkg::KIND_UINT;
                end else if (is_l) begin
                    kind_next = cils_pkg::KIND_LONG;
                end else begin
                    close = 1'b1;
                    fl    = (radix_reg != cils_pkg::RX_HEX) && is_float_ch;
                end
            end
            cils_pkg::PH_AFTU: begin
                if (is_l) begin
                    kind_next = cils_pkg::KIND_ULONG;
                end else begin
                    close = 1'b1;
                end
            end
            cils_pkg::PH_AFTL: begin
                if (is_l) begin
                    kind_next = (kind_reg == cils_pkg::KIND_ULONG) ? cils_pkg::KIND_ULLONG
                                                                   : cils_pkg::KIND_LLONG;
                end else begin
                    close = 1'b1;
                end
            end
            default: begin
                close = 1'b1;
            end
        endcase

        res_valid         = close;
        res.value         = hexmiss ? '0 : accum_reg;
        res.exceeds_32    = !hexmiss && over32_reg;
        res.exceeds_64    = !hexmiss && over64_reg;
        res.kind          = hexmiss ? cils_pkg::KIND_INT : kind_reg;
        res.hex_missing   = hexmiss;
        res.float_follows = fl;

        // While idle the literal state is already clear, so the same path serves both.
        if (close || phase_reg == cils_pkg::PH_IDLE) begin
            radix_next  = cils_pkg::RX_DEC;
            accum_next  = '0;
            over32_next = 1'b0;
            over64_next = 1'b0;
            kind_next   = cils_pkg::KIND_INT;
            if (start && ch == CH_ZERO) begin
                radix_next = cils_pkg::RX_OCT;
            end else if (start && is_nz_digit) begin
                accum_next = {{(cils_pkg::VALUE_W-4){1'b0}}, ch[3:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= cils_pkg::PH_IDLE;
            radix_reg  <= cils_pkg::RX_DEC;
            accum_reg  <= '0;
            over32_reg <= 1'b0;
            over64_reg <= 1'b0;
            kind_reg   <= cils_pkg::KIND_INT;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            radix_reg  <= radix_next;
            accum_reg  <= accum_next;
            over32_reg <= over32_next;
            over64_reg <= over64_next;
            kind_reg   <= kind_next;
        end
    end

endmodule

FILE: sim/c_integer_literal_scanner_tb.sv
// Self-checking testbench of the C integer literal scanner: directed and random byte streams.
`timescale 1ns / 100ps

module c_integer_literal_scanner_tb;

    localparam int unsigned NO_DIGIT    = 16;
    localparam logic [63:0] ALL_ONES    = '1;
    localparam int unsigned RANDOM_BYTES = 330;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] ch
    logic        s_tuser  = 1'b0;   // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [63:0] value
    logic [6:0]  m_tuser;           // [0] exceeds_32, [1] exceeds_64, [4:2] kind,
                                    // [5] hex_missing, [6] float_follows

    cils_pkg::result_t pending_tokens[$];
    int unsigned error_count  = 0;
    int unsigned busy_bytes   = 0;
    int unsigned burst_left   = 0;
    bit          gaps_enabled = 1'b1;
    int unsigned hold_request = 0;

    // Scanner state as the predictor sees it.
    cils_pkg::phase_t scan_phase;
    cils_pkg::radix_t scan_radix;
    logic [63:0]      scan_accum;
    logic             scan_over32;
    logic             scan_over64;
    cils_pkg::kind_t  scan_kind;

    c_integer_literal_scanner u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned digit_value(input logic [7:0] c,
                                                input cils_pkg::radix_t rx);
        int unsigned d;
        d = NO_DIGIT;
        if (c >= "0" && c <= "9") begin
            d = 32'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            d = 32'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            d = 32'(c - "A" + 8'd10);
        end
        if (rx == cils_pkg::RX_OCT && d >= 8) begin
            d = NO_DIGIT;
        end else if (rx == cils_pkg::RX_DEC && d >= 10) begin
            d = NO_DIGIT;
        end
        return d;
    endfunction

    function automatic void drop_literal();
        scan_phase  = cils_pkg::PH_IDLE;
        scan_radix  = cils_pkg::RX_DEC;
        scan_accum  = '0;
        scan_over32 = 1'b0;
        scan_over64 = 1'b0;
        scan_kind   = cils_pkg::KIND_INT;
    endfunction

    function automatic void open_literal(input logic [7:0] c);
        drop_literal();
        if (c == "0") begin
            scan_phase = cils_pkg::PH_ZERO;
            scan_radix = cils_pkg::RX_OCT;
        end else if (c >= "1" && c <= "9") begin
            scan_phase = cils_pkg::PH_DIGITS;
            scan_accum = 64'(c - "0");
        end
    endfunction

    function automatic void fold_digit(input int unsigned d);
        logic [63:0] r;
        logic [63:0] lim;
        r = (scan_radix == cils_pkg::RX_HEX) ? 64'd16 :
            ((scan_radix == cils_pkg::RX_OCT) ? 64'd8 : 64'd10);
        lim = (ALL_ONES - 64'(d)) / r;
        if (scan_accum > lim) begin
            scan_over64 = 1'b1;
        end
        scan_accum = scan_accum * r + 64'(d);
        if (scan_over64 || scan_accum > 64'hFFFF_FFFF) begin
            scan_over32 = 1'b1;
        end
    endfunction

    function automatic void push_token(input logic hexmiss, input logic fl);
        cils_pkg::result_t t;
        t.value         = hexmiss ? '0 : scan_accum;
        t.exceeds_32    = hexmiss ? 1'b0 : scan_over32;
        t.exceeds_64    = hexmiss ? 1'b0 : scan_over64;
        t.kind          = hexmiss ? cils_pkg::KIND_INT : scan_kind;
        t.hex_missing   = hexmiss;
        t.float_follows = fl;
        pending_tokens.push_back(t);
    endfunction

    // One step of the literal scanner for an accepted byte.
    function automatic void scan_byte(input logic [7:0] c, input logic s);
        int unsigned d;
        logic is_u;
        logic is_l;
        logic ended;
        is_u  = (c == "U" || c == "u");
        is_l  = (c == "L" || c == "l");
        ended = 1'b0;
        if (scan_phase != cils_pkg::PH_IDLE || s) begin
            busy_bytes++;
        end
        if (scan_phase != cils_pkg::PH_IDLE) begin
            case (scan_phase)
                cils_pkg::PH_HEXPFX: begin
                    d = digit_value(c, cils_pkg::RX_HEX);
                    if (!s && d < NO_DIGIT) begin
                        fold_digit(d);
                        scan_phase = cils_pkg::PH_DIGITS;
                    end else begin
                        push_token(1'b1, 1'b0);
                        ended = 1'b1;
                    end
                end
                cils_pkg::PH_ZERO, cils_pkg::PH_DIGITS: begin
                    d = digit_value(c, scan_radix);
                    if (!s && scan_phase == cils_pkg::PH_ZERO && (c == "x" || c == "X")) begin
                        scan_phase = cils_pkg::PH_HEXPFX;
                        scan_radix = cils_pkg::RX_HEX;
                    end else if (!s && d < NO_DIGIT) begin
                        fold_digit(d);
                        scan_phase = cils_pkg::PH_DIGITS;
                    end else if (!s && is_u) begin
                        scan_kind  = cils_pkg::KIND_UINT;
                        scan_phase = cils_pkg::PH_AFTU;
                    end else if (!s && is_l) begin
                        scan_kind  = cils_pkg::KIND_LONG;
                        scan_phase = cils_pkg::PH_AFTL;
                    end else begin
                        push_token(1'b0, scan_radix != cils_pkg::RX_HEX &&
                                         (c == "." || c == "e" || c == "E"));
                        ended = 1'b1;
                    end
                end
                cils_pkg::PH_AFTU: begin
                    if (!s && is_l) begin
                        scan_kind  = cils_pkg::KIND_ULONG;
                        scan_phase = cils_pkg::PH_AFTL;
                    end else begin
                        push_token(1'b0, 1'b0);
                        ended = 1'b1;
                    end
                end
                cils_pkg::PH_AFTL: begin
                    if (!s && is_l) begin
                        scan_kind  = (scan_kind == cils_pkg::KIND_ULONG) ? cils_pkg::KIND_ULLONG
                                                                         : cils_pkg::KIND_LLONG;
                        scan_phase = cils_pkg::PH_SUFEND;
                    end else begin
                        push_token(1'b0, 1'b0);
                        ended = 1'b1;
                    end
                end
                default: begin
                    push_token(1'b0, 1'b0);
                    ended = 1'b1;
                end
            endcase
        end
        if (ended) begin
            drop_literal();
        end
        if (s) begin
            open_literal(c);
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic s);
        if (gaps_enabled && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= s;
        do @(posedge aclk); while (!s_tready);
        scan_byte(c, s);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_byte(txt[i], i == 0);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] any_case(input logic [7:0] upper);
        return ($urandom_range(0, 1) != 0) ? (upper | 8'h20) : upper;
    endfunction

    function automatic logic [7:0] random_digit(input cils_pkg::radix_t rx, input bit full);
        int unsigned d;
        case (rx)
            cils_pkg::RX_DEC: d = full ? 9 : $urandom_range(0, 9);
            cils_pkg::RX_OCT: d = full ? 7 : $urandom_range(0, 7);
            default:          d = full ? 15 : $urandom_range(0, 15);
        endcase
        if (d < 10) begin
            return 8'("0" + d);
        end
        return any_case(8'("A" + d - 10));
    endfunction

    // A literal with random digits, a random and sometimes malformed suffix, and an optional terminator.
    task automatic send_random_literal();
        cils_pkg::radix_t rx;
        int unsigned      ndig;
        bit               full;
        string            sfx;
        string            seps;
        logic [7:0]       sep;
        seps = " ,;)+\n";
        case ($urandom_range(0, 2))
            0:       rx = cils_pkg::RX_DEC;
            1:       rx = cils_pkg::RX_OCT;
            default: rx = cils_pkg::RX_HEX;
        endcase
        full = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) == 0) begin
            case (rx)
                cils_pkg::RX_DEC: ndig = $urandom_range(9, 21);
                cils_pkg::RX_OCT: ndig = $urandom_range(10, 22);
                default:          ndig = full ? $urandom_range(15, 17) : $urandom_range(7, 17);
            endcase
        end else begin
            ndig = $urandom_range(0, 3);
        end
        if (rx == cils_pkg::RX_DEC) begin
            send_byte(full ? 8'("9") : 8'("1" + $urandom_range(0, 8)), 1'b1);
        end else begin
            send_byte("0", 1'b1);
            if (rx == cils_pkg::RX_HEX) begin
                send_byte(any_case("X"), 1'b0);
            end
        end
        repeat (ndig) send_byte(random_digit(rx, full), 1'b0);
        case ($urandom_range(0, 9))
            4:       sfx = "U";
            5:       sfx = "L";
            6:       sfx = "UL";
            7:       sfx = "LL";
            8:       sfx = "ULL";
            9: begin
                case ($urandom_range(0, 2))
                    0:       sfx = "LU";
                    1:       sfx = "LLL";
                    default: sfx = "UU";
                endcase
            end
            default: sfx = "";
        endcase
        for (int i = 0; i < sfx.len(); i++) begin
            send_byte(any_case(sfx[i]), 1'b0);
        end
        // Without a terminator the next start byte closes the literal.
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                sep = seps[$urandom_range(0, seps.len() - 1)];
                send_byte(sep, 1'b0);
            end
            3:       send_byte(".", 1'b0);
            4:       send_byte(any_case("E"), 1'b0);
            8:       send_byte(8'($urandom_range(0, 255)), 1'b0);
            9:       send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
            default: ;
        endcase
    endtask

    task automatic test_directed();
        // Idle bytes at both ends of the byte range are ignored.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("0xg");
        send_text("7.");
        send_text("09");
        send_text("1ULL");
        // The start byte closes the previous literal; after an L a U ends it.
        send_text("5LU");
        // A start byte that is not a digit opens nothing.
        send_byte("a", 1'b1);
        send_byte(8'hFF, 1'b1);
        send_text("0xA.");
        send_text("3lll");
        send_text("2ue");
        send_text("8uu");
        wait_drained();
    endtask

    task automatic test_random_text();
        int unsigned first;
        first = busy_bytes;
        while (busy_bytes - first < RANDOM_BYTES) begin
            if ($urandom_range(0, 19) < 3) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                send_random_literal();
            end
        end
    endtask

    // The receiver holds off while the sender keeps offering transfers.
    task automatic test_output_stall();
        gaps_enabled = 1'b0;
        hold_request = 80;
        repeat (12) send_random_literal();
        gaps_enabled = 1'b1;
        wait_drained();
    endtask

    task automatic test_flush();
        send_byte(" ", 1'b0);
        wait_drained();
        repeat (8) @(posedge aclk);
    endtask

    initial begin : receiver
        int unsigned mode;
        int unsigned left;
        int unsigned hold_len;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_len = hold_request;
                m_tready <= 1'b0;
                for (int i = 0; i < hold_len; i++) @(posedge aclk);
                hold_request = 0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 48);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic check_field(input string field_name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        cils_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: result transfer with nothing expected: expected none, actual %h %b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("value", want.value, m_tdata);
                check_field("exceeds_32", want.exceeds_32, m_tuser[0]);
                check_field("exceeds_64", want.exceeds_64, m_tuser[1]);
                check_field("kind", want.kind, m_tuser[4:2]);
                check_field("hex_missing", want.hex_missing, m_tuser[5]);
                check_field("float_follows", want.float_follows, m_tuser[6]);
            end
        end
    end

    initial begin
        drop_literal();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_text();
        test_output_stall();
        test_flush();
        if (error_count == 0) begin
            $display("c_integer_literal_scanner_tb passed");
        end else begin
            $display("c_integer_literal_scanner_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("c_integer_literal_scanner_tb failed");
        $finish;
    end

endmodule
